### hdl/bss_pkg.sv
// Shared types, constants and codes for the Burgers stencil stepper.
`default_nettype none

package bss_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int SAMPLE_W   = 32;
  localparam int FRAC_BITS  = 24;
  localparam int COEFF_W    = 26;
  localparam int PTS_W      = 11;
  localparam int STEP_W     = 16;
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 26;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int MAG_W      = PROD_W - FRAC_BITS;
  localparam int MIN_POINTS = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam logic [COEFF_W-1:0] ADVECT_RST  = COEFF_W'(1174405);
  localparam logic [COEFF_W-1:0] DIFFUSE_RST = COEFF_W'(13083711);
  localparam logic [PTS_W-1:0]   POINTS_RST  = PTS_W'(1024);

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ADVECT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS  = 2'd2;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } alu_rsp_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  point_index;
    sample_t           point_value;
    logic [STEP_W-1:0] step_count;
  } in_item_t;

  typedef struct packed {
    sample_t read_value;
    logic    is_step_done;
    logic    saturated;
  } out_item_t;

endpackage

`default_nettype wire

### hdl/bss_alu.sv
// Shared saturating add/subtract and rounding fixed-point multiply unit.
`default_nettype none

module bss_alu (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bss_pkg::alu_req_t alu_req,
  input  wire bss_pkg::sample_t  opa,
  input  wire bss_pkg::sample_t  opb,
  output bss_pkg::alu_rsp_t      alu_rsp,
  output bss_pkg::sample_t       result
);
  import bss_pkg::*;

  typedef enum logic [1:0] {
    U_IDLE,
    U_RND,
    U_FIN
  } ustate_t;

  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  ustate_t                  st_r;
  logic                     done_r;
  logic                     sat_r;
  sample_t                  res_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [MAG_W-1:0]         mag_r;
  logic                     neg_r;

  logic signed [SAMPLE_W:0] ext_a, ext_b, sum_w;
  logic                     as_sat;
  sample_t                  as_res;
  logic signed [PROD_W-1:0] prod_w;
  logic [PROD_W-1:0]        abs_w, rnd_w;
  logic [MAG_W-1:0]         lim_w;
  logic                     mul_sat;
  sample_t                  mul_res;

  always_comb begin
    ext_a  = {opa[SAMPLE_W-1], opa};
    ext_b  = {opb[SAMPLE_W-1], opb};
    sum_w  = (alu_req.op == ALU_SUB) ? (ext_a - ext_b) : (ext_a + ext_b);
    as_sat = sum_w[SAMPLE_W] ^ sum_w[SAMPLE_W-1];
    as_res = as_sat ? (sum_w[SAMPLE_W] ? SMP_MIN : SMP_MAX) : sum_w[SAMPLE_W-1:0];
  end

  assign prod_w = PROD_W'(opa) * PROD_W'(opb);

  always_comb begin
    abs_w   = prod_r[PROD_W-1] ? (-prod_r) : prod_r;
    rnd_w   = abs_w + RND_HALF;
    lim_w   = {{(MAG_W-SAMPLE_W){1'b0}}, SMP_MAX} + (neg_r ? MAG_W'(1) : MAG_W'(0));
    mul_sat = (mag_r > lim_w);
    if (mul_sat) begin
      mul_res = neg_r ? SMP_MIN : SMP_MAX;
    end else if (neg_r) begin
      mul_res = -mag_r[SAMPLE_W-1:0];
    end else begin
      mul_res = mag_r[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        U_IDLE: begin
          if (alu_req.start) begin
            if (alu_req.op == ALU_MUL) begin
              prod_r <= prod_w;
              st_r   <= U_RND;
            end else begin
              res_r  <= as_res;
              sat_r  <= as_sat;
              done_r <= 1'b1;
            end
          end
        end
        U_RND: begin
          mag_r <= rnd_w[PROD_W-1:FRAC_BITS];
          neg_r <= prod_r[PROD_W-1];
          st_r  <= U_FIN;
        end
        U_FIN: begin
          res_r  <= mul_res;
          sat_r  <= mul_sat;
          done_r <= 1'b1;
          st_r   <= U_IDLE;
        end
        default: st_r <= U_IDLE;
      endcase
    end
  end

  assign alu_rsp.done = done_r;
  assign alu_rsp.sat  = sat_r;
  assign result       = res_r;

endmodule

`default_nettype wire

### hdl/burgers_1d_stencil_stepper_unit.sv
// Top level of the 1-D viscous Burgers stencil stepper.
`default_nettype none

// Holds a periodic 1-D velocity field of up to 1024 signed Q8.24 samples in one RAM
// (one write and one registered read port) and advances it with an upwind advection
// plus central diffusion rule. A write transaction stores a point on acceptance and
// produces no result. A read transaction's sample passes from the RAM read register
// through rpt_value_r into the output register. An advance transaction runs
// step_count time steps over the clamped point count: every grid point runs eight
// operations in turn through one shared add, subtract and multiply unit.
// The input is not ready while a transaction is at work; a finished result
// waits in an output register. The field RAM is not cleared at reset: read only
// points that were written. The configuration port is always ready.
module burgers_1d_stencil_stepper_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire bss_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output bss_pkg::out_item_t                      out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bss_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDWAIT,
    S_REPORT,
    S_LD_NM2,
    S_LD_0,
    S_LD_1,
    S_LD_END,
    S_CALC,
    S_NEXT,
    S_GET,
    S_WR,
    S_WB0,
    S_WBL
  } state_t;

  typedef enum logic [2:0] {
    UOP_DL,
    UOP_DR,
    UOP_LAP,
    UOP_UDL,
    UOP_ADV,
    UOP_DIF,
    UOP_SUB,
    UOP_NEW
  } uop_t;

  state_t              state_r;
  uop_t                upc_r;
  logic                wait_r;
  logic                edge_r;
  logic [ADDR_W-1:0]   idx_r;
  logic [PTS_W-1:0]    n_r;
  logic [STEP_W-1:0]   steps_left_r;
  logic                sat_flag_r;
  logic                out_valid_r;
  out_item_t           out_data_r;
  sample_t             rpt_value_r;
  logic                rpt_done_r;

  logic [COEFF_W-1:0]  advect_r;
  logic [COEFF_W-1:0]  diffuse_r;
  logic [PTS_W-1:0]    points_r;

  sample_t ul_r, u_r, ur_r;
  sample_t dl_r, dr_r, lap_r, t_r, adv_r, dif_r, s_r, new_r, new0_r;

  sample_t             field_mem [MAX_POINTS];
  sample_t             rd_data_r;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  sample_t             wr_data;

  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;
  sample_t             alu_a, alu_b, alu_res;

  logic                in_fire;
  logic                out_free;
  logic [PTS_W-1:0]    n_eff;
  logic [PTS_W-1:0]    n_m2;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    if (points_r < PTS_W'(MIN_POINTS)) begin
      n_eff = PTS_W'(MIN_POINTS);
    end else if (points_r > PTS_W'(MAX_POINTS)) begin
      n_eff = PTS_W'(MAX_POINTS);
    end else begin
      n_eff = points_r;
    end
  end

  assign n_m2 = n_r - PTS_W'(2);

  // RAM port control
  always_comb begin
    case (state_r)
      S_IDLE:   rd_addr = in_data.point_index;
      S_LD_NM2: rd_addr = n_m2[ADDR_W-1:0];
      S_LD_0:   rd_addr = '0;
      S_LD_1:   rd_addr = ADDR_W'(1);
      default:  rd_addr = idx_r + ADDR_W'(1);
    endcase
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = new_r;
    case (state_r)
      S_IDLE: begin
        wr_en   = in_fire && (in_data.cmd == CMD_WRITE);
        wr_addr = in_data.point_index;
        wr_data = in_data.point_value;
      end
      S_WR: wr_en = 1'b1;
      S_WB0: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = new0_r;
      end
      S_WBL: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(n_r - PTS_W'(1));
        wr_data = new0_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      field_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= field_mem[rd_addr];
  end

  // operand selection for the shared unit
  always_comb begin
    alu_req.start = (state_r == S_CALC) && !wait_r;
    alu_req.op    = ALU_SUB;
    alu_a         = u_r;
    alu_b         = ul_r;
    unique case (upc_r)
      UOP_DL:  begin alu_req.op = ALU_SUB; alu_a = u_r;   alu_b = ul_r;  end
      UOP_DR:  begin alu_req.op = ALU_SUB; alu_a = ur_r;  alu_b = u_r;   end
      UOP_LAP: begin alu_req.op = ALU_SUB; alu_a = dr_r;  alu_b = dl_r;  end
      UOP_UDL: begin alu_req.op = ALU_MUL; alu_a = u_r;   alu_b = dl_r;  end
      UOP_ADV: begin
        alu_req.op = ALU_MUL;
        alu_a      = t_r;
        alu_b      = sample_t'({{(SAMPLE_W-COEFF_W){1'b0}}, advect_r});
      end
      UOP_DIF: begin
        alu_req.op = ALU_MUL;
        alu_a      = lap_r;
        alu_b      = sample_t'({{(SAMPLE_W-COEFF_W){1'b0}}, diffuse_r});
      end
      UOP_SUB: begin alu_req.op = ALU_SUB; alu_a = u_r;   alu_b = adv_r; end
      UOP_NEW: begin alu_req.op = ALU_ADD; alu_a = s_r;   alu_b = dif_r; end
      default: begin alu_req.op = ALU_SUB; alu_a = u_r;   alu_b = ul_r;  end
    endcase
  end

  bss_alu u_alu (
    .clk     (clk),
    .rst_n   (rst_n),
    .alu_req (alu_req),
    .opa     (alu_a),
    .opb     (alu_b),
    .alu_rsp (alu_rsp),
    .result  (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      advect_r  <= ADVECT_RST;
      diffuse_r <= DIFFUSE_RST;
      points_r  <= POINTS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ADVECT:  advect_r  <= cfg_data;
        REG_DIFFUSE: diffuse_r <= cfg_data;
        REG_POINTS:  points_r  <= cfg_data[PTS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      upc_r        <= UOP_DL;
      wait_r       <= 1'b0;
      edge_r       <= 1'b0;
      steps_left_r <= '0;
      sat_flag_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_data.cmd)
              CMD_STEP: begin
                steps_left_r <= in_data.step_count;
                n_r          <= n_eff;
                if (in_data.step_count == '0) begin
                  rpt_value_r <= '0;
                  rpt_done_r  <= 1'b1;
                  state_r     <= S_REPORT;
                end else begin
                  state_r <= S_LD_NM2;
                end
              end
              CMD_READ: state_r <= S_RDWAIT;
              default: ;
            endcase
          end
        end
        S_RDWAIT: begin
          rpt_value_r <= rd_data_r;
          rpt_done_r  <= 1'b0;
          state_r     <= S_REPORT;
        end
        S_REPORT: begin
          if (out_free) begin
            out_valid_r             <= 1'b1;
            out_data_r.read_value   <= rpt_value_r;
            out_data_r.is_step_done <= rpt_done_r;
            out_data_r.saturated    <= sat_flag_r;
            sat_flag_r              <= 1'b0;
            state_r                 <= S_IDLE;
          end
        end
        S_LD_NM2: state_r <= S_LD_0;
        S_LD_0: begin
          ul_r    <= rd_data_r;
          state_r <= S_LD_1;
        end
        S_LD_1: begin
          u_r     <= rd_data_r;
          state_r <= S_LD_END;
        end
        S_LD_END: begin
          ur_r    <= rd_data_r;
          edge_r  <= 1'b1;
          upc_r   <= UOP_DL;
          wait_r  <= 1'b0;
          state_r <= S_CALC;
        end
        S_CALC: begin
          if (!wait_r) begin
            wait_r <= 1'b1;
          end else if (alu_rsp.done) begin
            wait_r <= 1'b0;
            if (alu_rsp.sat) begin
              sat_flag_r <= 1'b1;
            end
            unique case (upc_r)
              UOP_DL:  dl_r  <= alu_res;
              UOP_DR:  dr_r  <= alu_res;
              UOP_LAP: lap_r <= alu_res;
              UOP_UDL: t_r   <= alu_res;
              UOP_ADV: adv_r <= alu_res;
              UOP_DIF: dif_r <= alu_res;
              UOP_SUB: s_r   <= alu_res;
              UOP_NEW: new_r <= alu_res;
              default: ;
            endcase
            if (upc_r == UOP_NEW) begin
              if (edge_r) begin
                // point 0 is held until the sweep has used the old level
                new0_r  <= alu_res;
                ul_r    <= u_r;
                u_r     <= ur_r;
                idx_r   <= ADDR_W'(1);
                edge_r  <= 1'b0;
                state_r <= S_NEXT;
              end else begin
                state_r <= S_WR;
              end
            end else begin
              upc_r <= uop_t'(upc_r + 3'd1);
            end
          end
        end
        S_NEXT: state_r <= S_GET;
        S_GET: begin
          ur_r    <= rd_data_r;
          upc_r   <= UOP_DL;
          wait_r  <= 1'b0;
          state_r <= S_CALC;
        end
        S_WR: begin
          if (PTS_W'(idx_r) == n_m2) begin
            state_r <= S_WB0;
          end else begin
            ul_r    <= u_r;
            u_r     <= ur_r;
            idx_r   <= idx_r + ADDR_W'(1);
            state_r <= S_NEXT;
          end
        end
        S_WB0: state_r <= S_WBL;
        S_WBL: begin
          steps_left_r <= steps_left_r - STEP_W'(1);
          if (steps_left_r == STEP_W'(1)) begin
            rpt_value_r <= '0;
            rpt_done_r  <= 1'b1;
            state_r     <= S_REPORT;
          end else begin
            state_r <= S_LD_NM2;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_alu_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> (wait_r && (state_r == S_CALC)))
    else $error("shared unit finished with no operation outstanding");

  a_report_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REPORT) && out_valid_r && !out_ready |=> (state_r == S_REPORT))
    else $error("result loaded over a pending transaction");

  a_flag_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REPORT) && out_free |=> (out_valid_r && !sat_flag_r))
    else $error("saturation flag not cleared on report");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> ((PTS_W'(idx_r) <= n_m2) && (idx_r != '0)))
    else $error("sweep index outside the interior");

  a_steps_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LD_NM2) |-> (steps_left_r != '0))
    else $error("time step started with none left");

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking testbench for the 1-D Burgers stencil stepper: random commands vs a predictor.
`timescale 1ns / 100ps

module tb;
  import bss_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam longint S_HI = 64'sd2147483647;
  localparam longint S_LO = -64'sd2147483648;
  localparam int LONGEST_STEP = 65535 * (25 * MIN_POINTS - 22) + 2;
  localparam int WATCHDOG_LIMIT = 3 * LONGEST_STEP;
  localparam int SETTLE = 8;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_ITEMS = 65;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  burgers_1d_stencil_stepper_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  longint field_model[MAX_POINTS];
  longint next_level[MAX_POINTS];
  bit sat_sticky = 1'b0;
  logic [COEFF_W-1:0] advect_reg = ADVECT_RST;
  logic [COEFF_W-1:0] diffuse_reg = DIFFUSE_RST;
  logic [PTS_W-1:0] points_reg = POINTS_RST;

  in_item_t queued_commands[$];
  out_item_t due_reports[$];
  out_item_t want;
  int commands_queued = 0;
  int commands_taken = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  bit cmd_taken = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;

  // stimulus bookkeeping
  bit point_written[MAX_POINTS];
  int written_idx[$];
  int live_points = MAX_POINTS;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint clamp_sample(longint v);
    if (v > S_HI) begin
      sat_sticky = 1'b1;
      return S_HI;
    end
    if (v < S_LO) begin
      sat_sticky = 1'b1;
      return S_LO;
    end
    return v;
  endfunction

  // Q.24 product, rounded half away from zero, saturated
  function automatic longint fixed_mul(longint x, longint y);
    longint p;
    longint mag;
    bit neg;
    neg = (x < 0) != (y < 0);
    p = x * y;
    if (p < 0) p = -p;
    mag = (p + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (mag > S_HI + (neg ? 1 : 0)) begin
      sat_sticky = 1'b1;
      return neg ? S_LO : S_HI;
    end
    return neg ? -mag : mag;
  endfunction

  function automatic longint next_velocity(longint u, longint ul, longint ur);
    longint dl, dr, lap, adv, dif;
    dl = clamp_sample(u - ul);
    dr = clamp_sample(ur - u);
    lap = clamp_sample(dr - dl);
    adv = fixed_mul(fixed_mul(u, dl), longint'(advect_reg));
    dif = fixed_mul(lap, longint'(diffuse_reg));
    return clamp_sample(clamp_sample(u - adv) + dif);
  endfunction

  function automatic void advance_field(int n);
    int i;
    for (i = 1; i < n - 1; i++)
      next_level[i] = next_velocity(field_model[i], field_model[i-1], field_model[i+1]);
    next_level[0] = next_velocity(field_model[0], field_model[n-2], field_model[1]);
    next_level[n-1] = next_level[0];
    for (i = 0; i < n; i++) field_model[i] = next_level[i];
  endfunction

  function automatic int clamp_points(logic [PTS_W-1:0] raw);
    if (raw < MIN_POINTS) return MIN_POINTS;
    if (raw > MAX_POINTS) return MAX_POINTS;
    return int'(raw);
  endfunction

  function automatic void apply_command(in_item_t c);
    out_item_t r;
    int n;
    int k;
    r = '0;
    case (c.cmd)
      CMD_WRITE: field_model[c.point_index] = longint'(c.point_value);
      CMD_STEP: begin
        n = clamp_points(points_reg);
        for (k = 0; k < int'(c.step_count); k++) advance_field(n);
        r.is_step_done = 1'b1;
        r.saturated = sat_sticky;
        sat_sticky = 1'b0;
        due_reports.push_back(r);
      end
      CMD_READ: begin
        r.read_value = sample_t'(field_model[c.point_index]);
        r.saturated = sat_sticky;
        sat_sticky = 1'b0;
        due_reports.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // checking, prediction and watchdog share one edge process
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          error_count++;
        end else begin
          want = due_reports.pop_front();
          if (out_data.read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                     out_data.read_value);
            error_count++;
          end
          if (out_data.is_step_done !== want.is_step_done) begin
            $display("%0t: is_step_done expected %b actual %b", $time, want.is_step_done,
                     out_data.is_step_done);
            error_count++;
          end
          if (out_data.saturated !== want.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                     out_data.saturated);
            error_count++;
          end
        end
      end
      cmd_taken = in_valid && in_ready;
      if (cmd_taken) begin
        apply_command(in_data);
        commands_taken++;
      end
      if (cmd_taken || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // command driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || cmd_taken) begin
      if (queued_commands.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= queued_commands.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and long hold-offs on request
  always @(negedge clk) begin
    if (hold_reqs != hold_served) begin
      hold_served = hold_reqs;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic in_item_t random_cmd(logic [CMD_W-1:0] op);
    in_item_t c;
    c.cmd = op;
    c.point_index = IDX_W'($urandom);
    c.point_value = sample_t'($urandom);
    c.step_count = STEP_W'($urandom);
    return c;
  endfunction

  function automatic in_item_t write_cmd(int idx, sample_t v);
    in_item_t c;
    c = random_cmd(CMD_WRITE);
    c.point_index = IDX_W'(idx);
    c.point_value = v;
    return c;
  endfunction

  function automatic in_item_t read_cmd(int idx);
    in_item_t c;
    c = random_cmd(CMD_READ);
    c.point_index = IDX_W'(idx);
    return c;
  endfunction

  function automatic in_item_t step_cmd(int n);
    in_item_t c;
    c = random_cmd(CMD_STEP);
    c.step_count = STEP_W'(n);
    return c;
  endfunction

  function automatic sample_t random_value();
    case ($urandom_range(6))
      0: return sample_t'($urandom);
      1: return $urandom_range(1) ? SMP_MAX : SMP_MIN;
      2: return sample_t'(int'($urandom_range(1 << 22)) - (1 << 21));
      default: return sample_t'(int'($urandom_range(1 << 26)) - (1 << 25));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_coeff();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return CFG_DATA_W'(ADVECT_RST);
      3: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(1 << 24));
    endcase
  endfunction

  function automatic int pick_points();
    case ($urandom_range(9))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return MIN_POINTS;
      4: return $urandom_range(40, 17);
      default: return $urandom_range(16, 4);
    endcase
  endfunction

  task automatic enqueue(input in_item_t c);
    if (c.cmd == CMD_WRITE && !point_written[c.point_index]) begin
      point_written[c.point_index] = 1'b1;
      written_idx.push_back(int'(c.point_index));
    end
    queued_commands.push_back(c);
    commands_queued++;
  endtask

  task automatic wait_idle();
    while (!(commands_taken == commands_queued && due_reports.size() == 0)) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ADVECT: advect_reg = val[COEFF_W-1:0];
      REG_DIFFUSE: diffuse_reg = val[COEFF_W-1:0];
      REG_POINTS: begin
        points_reg = val[PTS_W-1:0];
        live_points = clamp_points(points_reg);
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input bit long_hold);
    int budget;
    int idx;
    int kind;
    int n;
    logic [CFG_DATA_W-1:0] raw_points;
    set_reg(REG_ADVECT, pick_coeff());
    set_reg(REG_DIFFUSE, pick_coeff());
    raw_points = CFG_DATA_W'($urandom);
    raw_points[PTS_W-1:0] = PTS_W'(pick_points());
    set_reg(REG_POINTS, raw_points);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (long_hold) hold_reqs++;
    budget = 0;
    for (idx = 0; idx < live_points; idx++) begin
      if (!point_written[idx] || $urandom_range(1)) begin
        enqueue(write_cmd(idx, random_value()));
        budget++;
      end
    end
    while (budget < PHASE_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 5) begin
        enqueue(random_cmd(CMD_UNUSED));
      end else begin
        budget++;
        if (kind < 38) begin
          idx = ($urandom_range(3) == 0) ? $urandom_range(MAX_POINTS - 1)
                                         : $urandom_range(live_points - 1);
          enqueue(write_cmd(idx, random_value()));
        end else if (kind < 60) begin
          if (live_points > 16) n = $urandom_range(3);
          else if ($urandom_range(4) == 0) n = $urandom_range(120, 13);
          else n = $urandom_range(12);
          enqueue(step_cmd(n));
        end else begin
          idx = ($urandom_range(3) == 0) ? written_idx[$urandom_range(written_idx.size() - 1)]
                                         : $urandom_range(live_points - 1);
          enqueue(read_cmd(idx));
        end
      end
    end
  endtask

  initial begin
    int ph;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset settings, field extremes, all commands, clamped point counts
    enqueue(step_cmd(0));
    enqueue(random_cmd(CMD_UNUSED));
    enqueue(write_cmd(0, SMP_MAX));
    enqueue(write_cmd(1, SMP_MIN));
    enqueue(write_cmd(2, '0));
    enqueue(write_cmd(MAX_POINTS - 1, sample_t'(32'h0100_0000)));
    enqueue(read_cmd(MAX_POINTS - 1));
    enqueue(read_cmd(0));
    enqueue(read_cmd(1));
    enqueue(read_cmd(2));
    set_reg(REG_POINTS, CFG_DATA_W'(MIN_POINTS));
    enqueue(step_cmd(1));
    enqueue(read_cmd(0));
    enqueue(read_cmd(1));
    enqueue(read_cmd(2));
    set_reg(REG_ADVECT, '1);
    set_reg(REG_DIFFUSE, '0);
    set_reg(REG_POINTS, CFG_DATA_W'(1));
    enqueue(write_cmd(0, sample_t'(32'h0080_0000)));
    enqueue(write_cmd(1, sample_t'(32'hFFC0_0000)));
    enqueue(write_cmd(2, sample_t'(32'h0100_0000)));
    enqueue(step_cmd(16'hFFFF));
    enqueue(read_cmd(0));
    enqueue(read_cmd(1));

    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: run_phase(0, 0, ph == 0);
        1: run_phase(68, 0, 1'b0);
        2: run_phase(0, 68, 1'b0);
        default: run_phase(28, 28, 1'b0);
      endcase
    end

    wait_idle();
    if (error_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
hdl/bss_pkg.sv
hdl/bss_alu.sv
hdl/burgers_1d_stencil_stepper_unit.sv
bench/tb.sv
